FILE: hw/rtl/bpad_pkg.sv
// Shared constants and types for the beacon period anomaly detector.
package bpad_pkg;

  localparam int TIME_BITS_DEF     = 48;
  localparam int AVG_FRAC_BITS_DEF = 8;

  // Fixed widths of the stream and configuration fields.
  localparam int IN_TIME_BITS  = 48;
  localparam int S_TDATA_BITS  = 56;
  localparam int M_TDATA_BITS  = 8;

  typedef struct packed {
    logic arrival_notify;
    logic anomaly_notify;
    logic net_change;
  } flags_t;

endpackage

FILE: hw/rtl/bpad_core.sv
// Beacon state (last time, averaged period) and per-beacon classification.
module bpad_core #(
  parameter int TIME_BITS     = bpad_pkg::TIME_BITS_DEF,
  parameter int AVG_FRAC_BITS = bpad_pkg::AVG_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic [bpad_pkg::IN_TIME_BITS-1:0] arrival_time,
  input  logic                              circuit_present,
  input  logic [bpad_pkg::IN_TIME_BITS-1:0] program_start_time,
  output bpad_pkg::flags_t                  flags
);
  import bpad_pkg::*;

  localparam int AW = TIME_BITS + AVG_FRAC_BITS;

  logic                 seen_first;
  logic                 seen_second;
  logic [TIME_BITS-1:0] last_time;
  logic [AW-1:0]        avg;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] start;
  logic [TIME_BITS-1:0] period;
  logic [TIME_BITS-1:0] running;
  logic [AW-1:0]        p;
  logic [AW+2:0]        p4_w3;
  logic [AW+2:0]        a5;
  logic [AW+2:0]        a4;
  logic [AW+2:0]        p5;
  logic [AW+3:0]        p4_w4;
  logic [AW+3:0]        a13;
  logic [AW+3:0]        sum7;
  logic                 ge_hi;
  logic                 ge_top;
  logic                 le_lo;
  logic                 seed_net;

  // Fit the fixed-width time fields to the internal time width.
  if (TIME_BITS <= IN_TIME_BITS) begin : g_trunc
    assign now   = arrival_time[TIME_BITS-1:0];
    assign start = program_start_time[TIME_BITS-1:0];
  end else begin : g_ext
    assign now   = {{(TIME_BITS-IN_TIME_BITS){1'b0}}, arrival_time};
    assign start = {{(TIME_BITS-IN_TIME_BITS){1'b0}}, program_start_time};
  end

  always_comb begin
    // Saturate a backward step to zero.
    period  = (now >= last_time) ? (now - last_time) : '0;
    running = last_time - start;
    p       = AW'(period) << AVG_FRAC_BITS;

    p4_w3 = (AW+3)'(p) << 2;
    a5    = (AW+3)'(avg) + ((AW+3)'(avg) << 2);
    a4    = (AW+3)'(avg) << 2;
    p5    = (AW+3)'(p) + ((AW+3)'(p) << 2);
    p4_w4 = (AW+4)'(p) << 2;
    a13   = (AW+4)'(avg) + ((AW+4)'(avg) << 2) + ((AW+4)'(avg) << 3);
    sum7  = ((AW+4)'(avg) << 3) - (AW+4)'(avg) + (AW+4)'(p);

    ge_hi    = p4_w3 >= a5;
    ge_top   = p4_w4 >= a13;
    le_lo    = a4 >= p5;
    seed_net = (last_time >= start) && (period <= running);
  end

  always_comb begin
    flags = '0;
    if (!seen_first) begin
      flags.anomaly_notify = circuit_present;
    end else if (!seen_second) begin
      flags.anomaly_notify = circuit_present;
      flags.net_change     = seed_net;
    end else if (ge_hi) begin
      flags.anomaly_notify = circuit_present;
      flags.net_change     = ge_top;
    end else if (le_lo) begin
      flags.anomaly_notify = circuit_present;
      flags.net_change     = 1'b1;
    end else begin
      flags.arrival_notify = circuit_present;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first  <= 1'b0;
      seen_second <= 1'b0;
      last_time   <= '0;
      avg         <= '0;
    end else if (step) begin
      last_time  <= now;
      seen_first <= 1'b1;
      if (seen_first && !seen_second) begin
        avg         <= p;
        seen_second <= 1'b1;
      end else if (seen_second) begin
        // 1/8 new period plus 7/8 old average, floored
        avg <= sum7[AW+2:3];
      end
    end
  end

endmodule

FILE: hw/rtl/beacon_period_anomaly_detector_top.sv
// Path: input register, then the classification and average update in bpad_core, then
// the result register, which a request enters only when it advances. Throughput: one
// request per cycle while m_tready is high; this is the only path.
// Reset (rst, synchronous): clears the beacon history, the average and the
// program start time to zero and empties both registers.
module beacon_period_anomaly_detector_top #(
  parameter int TIME_BITS     = bpad_pkg::TIME_BITS_DEF,
  parameter int AVG_FRAC_BITS = bpad_pkg::AVG_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [47:0] arrival_time, [48] circuit_present, [55:49] zero
  input  logic [bpad_pkg::S_TDATA_BITS-1:0] s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] net_change, [1] anomaly_notify, [2] arrival_notify, [7:3] zero
  output logic [bpad_pkg::M_TDATA_BITS-1:0] m_tdata,
  input  logic                              cfg_wr_en,
  input  logic [bpad_pkg::IN_TIME_BITS-1:0] cfg_wr_data
);
  import bpad_pkg::*;

  logic                    in_valid;
  logic [IN_TIME_BITS-1:0] in_time;
  logic                    in_circ;
  logic [IN_TIME_BITS-1:0] program_start_time;
  logic                    advance;
  flags_t                  flags;
  flags_t                  out_flags;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_start_time <= '0;
    end else if (cfg_wr_en) begin
      program_start_time <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_time <= s_tdata[IN_TIME_BITS-1:0];
      in_circ <= s_tdata[IN_TIME_BITS];
    end
  end

  bpad_core #(
    .TIME_BITS     (TIME_BITS),
    .AVG_FRAC_BITS (AVG_FRAC_BITS)
  ) u_core (
    .clk                (clk),
    .rst                (rst),
    .step               (advance),
    .arrival_time       (in_time),
    .circuit_present    (in_circ),
    .program_start_time (program_start_time),
    .flags              (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_flags <= flags;
    end
  end

  assign m_tdata = {{(M_TDATA_BITS-3){1'b0}}, out_flags.arrival_notify,
                    out_flags.anomaly_notify, out_flags.net_change};

endmodule

FILE: tb/beacon_period_anomaly_detector_top_tb.sv
`timescale 1ns / 1ps
// Stream testbench for the beacon period anomaly detector with a built-in flag predictor.
module beacon_period_anomaly_detector_top_tb;
  import bpad_pkg::*;

  localparam int TB_TIME      = IN_TIME_BITS;
  localparam int AVG_BITS     = IN_TIME_BITS + AVG_FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 350;
  localparam int SETTLE       = 4;
  localparam logic [TB_TIME-1:0] TIME_MAX = '1;

  // Packed so that it lands in s_tdata as-is: circuit at bit 48.
  typedef struct packed {
    logic               circuit;
    logic [TB_TIME-1:0] arrival;
  } beacon_t;

  typedef struct packed {
    logic                seen_first;
    logic                seen_second;
    logic [TB_TIME-1:0]  last;
    logic [AVG_BITS-1:0] avg;
  } beacon_hist_t;

  typedef struct packed {
    beacon_hist_t next;
    flags_t       flags;
  } verdict_t;

  typedef enum int {
    K_HEALTHY, K_LONG, K_HUGE, K_SHORT, K_ZERO, K_BACK, K_JUMP, K_REBASE,
    K_AT_125, K_BELOW_125, K_AT_325, K_AT_080, K_ABOVE_080
  } spacing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_BITS-1:0] m_tdata;
  logic cfg_wr_en = 1'b0;
  logic [IN_TIME_BITS-1:0] cfg_wr_data = '0;

  beacon_t      pending_beacons[$];
  flags_t       expected_flags[$];
  beacon_hist_t model_hist = '0;
  beacon_hist_t gen_hist = '0;
  logic [TB_TIME-1:0] prog_start = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int total_queued = 0;
  int results_seen = 0;
  int err_count = 0;
  int cycle_count = 0;

  beacon_t  drv_item;
  verdict_t drv_verdict;
  flags_t   mon_want;
  flags_t   mon_got;

  beacon_period_anomaly_detector_top dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // Classify one beacon against the history and return the updated history.
  function automatic verdict_t judge_beacon(beacon_hist_t h, beacon_t b,
                                            logic [TB_TIME-1:0] start);
    verdict_t v;
    logic [TB_TIME-1:0] period;
    logic [63:0] p;
    logic [63:0] a;
    logic [63:0] blend;
    v.next = h;
    v.flags = '0;
    if (!h.seen_first) begin
      v.flags.anomaly_notify = b.circuit;
      v.next.seen_first = 1'b1;
    end else begin
      period = (b.arrival >= h.last) ? b.arrival - h.last : '0;
      p = 64'(period) << AVG_FRAC_BITS_DEF;
      a = 64'(h.avg);
      if (!h.seen_second) begin
        v.flags.anomaly_notify = b.circuit;
        v.flags.net_change = (h.last >= start) && (period <= h.last - start);
        v.next.avg = p[AVG_BITS-1:0];
        v.next.seen_second = 1'b1;
      end else begin
        if (p * 4 >= a * 5) begin
          v.flags.anomaly_notify = b.circuit;
          v.flags.net_change = (p * 4 >= a * 13);
        end else if (a * 4 >= p * 5) begin
          v.flags.anomaly_notify = b.circuit;
          v.flags.net_change = 1'b1;
        end else begin
          v.flags.arrival_notify = b.circuit;
        end
        blend = (p + a * 7) >> 3;
        v.next.avg = blend[AVG_BITS-1:0];
      end
    end
    v.next.last = b.arrival;
    return v;
  endfunction

  // Arrival time that gives the wanted spacing from the generator's own history.
  function automatic logic [TB_TIME-1:0] next_arrival(spacing_t kind);
    logic [63:0] a;
    logic [63:0] aint;
    logic [63:0] period;
    logic [63:0] rnd;
    a = 64'(gen_hist.avg);
    aint = a >> AVG_FRAC_BITS_DEF;
    rnd = {$urandom, $urandom};
    period = '0;
    case (kind)
      K_HEALTHY: begin
        period = (aint == 0) ? 64'($urandom_range(50, 1))
                             : aint * $urandom_range(120, 88) / 100;
      end
      K_LONG:      period = aint * $urandom_range(400, 130) / 100 + 1;
      K_HUGE:      period = aint * $urandom_range(40, 4) + $urandom_range(1000, 1);
      K_SHORT:     period = aint * $urandom_range(78, 0) / 100;
      K_ZERO:      period = '0;
      K_BACK:      return gen_hist.last - TB_TIME'($urandom_range(1000, 1));
      K_JUMP:      return rnd[TB_TIME-1:0];
      K_REBASE:    period = rnd >> $urandom_range(63, 17);
      // Exact thresholds: 1024*period against 5A, 13A; 1280*period against 4A.
      K_AT_125:    period = (a * 5 + 1023) / 1024;
      K_BELOW_125: period = (a * 5 + 1023) / 1024 - ((a == 0) ? 0 : 1);
      K_AT_325:    period = (a * 13 + 1023) / 1024;
      K_AT_080:    period = (a * 4) / 1280;
      K_ABOVE_080: period = (a * 4) / 1280 + 1;
      default:     period = '0;
    endcase
    return gen_hist.last + period[TB_TIME-1:0];
  endfunction

  function automatic spacing_t pick_spacing();
    int r;
    r = $urandom_range(99);
    if (r < 50) return K_HEALTHY;
    if (r < 58) return K_LONG;
    if (r < 61) return K_HUGE;
    if (r < 67) return K_SHORT;
    if (r < 69) return K_ZERO;
    if (r < 72) return K_BACK;
    if (r < 75) return K_JUMP;
    if (r < 80) return K_REBASE;
    if (r < 84) return K_AT_125;
    if (r < 87) return K_BELOW_125;
    if (r < 90) return K_AT_325;
    if (r < 94) return K_AT_080;
    if (r < 97) return K_ABOVE_080;
    return K_HEALTHY;
  endfunction

  task automatic queue_beacon(logic [TB_TIME-1:0] t, logic c);
    beacon_t b;
    verdict_t v;
    b.arrival = t;
    b.circuit = c;
    v = judge_beacon(gen_hist, b, prog_start);
    gen_hist = v.next;
    pending_beacons.push_back(b);
    total_queued++;
  endtask

  task automatic queue_spacing(spacing_t kind, logic c);
    queue_beacon(next_arrival(kind), c);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      queue_spacing(pick_spacing(), $urandom_range(99) < 70);
    end
  endtask

  // Hold until every queued request has produced its result.
  task automatic drain();
    while (results_seen < total_queued) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_start(logic [TB_TIME-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    prog_start = value;
  endtask

  // Driver: predict on acceptance, then offer the next request or idle.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        drv_verdict = judge_beacon(model_hist, beacon_t'(s_tdata[TB_TIME:0]), prog_start);
        model_hist = drv_verdict.next;
        expected_flags.push_back(drv_verdict.flags);
      end
      if (!s_tvalid || s_tready) begin
        if (pending_beacons.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item = pending_beacons.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {{(S_TDATA_BITS - TB_TIME - 1){1'b0}}, drv_item};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: compare each result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      mon_got = flags_t'(m_tdata[2:0]);
      if (expected_flags.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected result: tdata=%02h", m_tdata);
      end else begin
        mon_want = expected_flags.pop_front();
        if (mon_got.net_change !== mon_want.net_change ||
            mon_got.anomaly_notify !== mon_want.anomaly_notify ||
            mon_got.arrival_notify !== mon_want.arrival_notify ||
            m_tdata[M_TDATA_BITS-1:3] !== '0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("result %0d mismatch: expected net=%0b anomaly=%0b arrival=%0b, got tdata=%02h",
                     results_seen, mon_want.net_change, mon_want.anomaly_notify,
                     mon_want.arrival_notify, m_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("beacon_period_anomaly_detector_top test failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Second beacon lands within the running time, so it reports a net change.
    write_start(48'd1000);
    queue_beacon(48'd5000, 1'b1);
    queue_beacon(48'd8000, 1'b1);
    queue_spacing(K_HEALTHY, 1'b1);
    queue_spacing(K_HEALTHY, 1'b0);
    queue_spacing(K_AT_125, 1'b1);
    queue_spacing(K_BELOW_125, 1'b1);
    queue_spacing(K_AT_325, 1'b1);
    queue_spacing(K_AT_325, 1'b0);
    queue_spacing(K_AT_080, 1'b1);
    queue_spacing(K_ABOVE_080, 1'b1);
    queue_spacing(K_ZERO, 1'b1);
    queue_spacing(K_BACK, 1'b1);
    queue_spacing(K_ZERO, 1'b0);
    queue_beacon(TIME_MAX, 1'b1);
    queue_beacon('0, 1'b1);
    queue_spacing(K_SHORT, 1'b0);
    queue_spacing(K_LONG, 1'b0);
    queue_spacing(K_HUGE, 1'b1);
    queue_spacing(K_REBASE, 1'b1);
    drain();

    // Full-rate sender against a long receiver hold to back up the pipeline.
    write_start('0);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req++;
    queue_random(RANDOM_ITEMS);
    drain();

    write_start(TIME_MAX);
    send_idle_pct = 49;
    stall_pct = 0;
    queue_random(RANDOM_ITEMS);
    drain();

    write_start(TB_TIME'({$urandom, $urandom}));
    send_idle_pct = 0;
    stall_pct = 49;
    queue_random(RANDOM_ITEMS);
    drain();

    send_idle_pct = 15;
    stall_pct = 15;
    hold_req++;
    queue_random(RANDOM_ITEMS);
    drain();

    repeat (8) @(posedge clk);
    if (expected_flags.size() != 0)
      $display("%0d predicted results never arrived", expected_flags.size());
    if (err_count == 0 && expected_flags.size() == 0) begin
      $display("beacon_period_anomaly_detector_top test passed");
    end else begin
      $display("beacon_period_anomaly_detector_top test failed");
    end
    $finish;
  end

endmodule
